// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers.
// Clocked implication checks that are switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/strb_pkg.sv =====
// ----------------------------------------------------------------------------
// strb_pkg: shared constants for the serial transmit/receive ring buffers.
// Operation and status codes and default sizes.
// ----------------------------------------------------------------------------
package strb_pkg;
  localparam int TX_RING_DEPTH_DEF = 1024;
  localparam int RX_RING_DEPTH_DEF = 1024;
  localparam int PACKET_MAX_DEF    = 64;
  localparam int READ_LIMIT        = 64;

  typedef enum logic [2:0] {
    OP_TX_BYTE = 3'd0, OP_FLUSH = 3'd1, OP_RX_BYTE = 3'd2,
    OP_RX_READ = 3'd3, OP_SET_LINK = 3'd4, OP_STATS = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_CONN = 3'd1, ST_OVERFLOW = 3'd2,
    ST_DROPPED = 3'd3, ST_NOTHING = 3'd4, ST_TX_FAIL = 3'd5
  } status_t;
endpackage

// ===== design/serial_tx_rx_ring_buffers.sv =====
// ----------------------------------------------------------------------------
// serial_tx_rx_ring_buffers: transmit and receive byte rings with stats.
// Two single-port-style synchronous rings, one keeping a slot free each.
// ----------------------------------------------------------------------------
// Every operation that yields one result (tx byte, rx byte, set link, stats,
// skipped flush or empty read) is done when it is accepted, so bytes can be
// enqueued back to back while the result side does not stall. A flush or a
// read that moves n bytes occupies the block until its last result: each byte
// is first read from the ring memory, whose data is registered, and then loaded
// into the output register, and input is held off until the last byte transfer
// has left the output register. Stalls on the result side lengthen a burst. Every
// result carries the counters and fill figures as they stand after its item has
// completed. Fill percentages are computed by a small multiply and shift when the
// item is accepted. Ring contents are not cleared at reset; only pointers, counters and control state are.
module serial_tx_rx_ring_buffers #(
  parameter int TX_RING_DEPTH = strb_pkg::TX_RING_DEPTH_DEF,
  parameter int RX_RING_DEPTH = strb_pkg::RX_RING_DEPTH_DEF,
  parameter int PACKET_MAX    = strb_pkg::PACKET_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [7:0]  data_byte,
  input  logic [14:0] msg_length,
  input  logic        first_of_message,
  input  logic [6:0]  max_count,
  input  logic        connected,
  input  logic        host_busy,
  input  logic        transmit_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic [14:0] rx_available,
  output logic [31:0] tx_byte_count,
  output logic [31:0] rx_byte_count,
  output logic [31:0] overflow_count,
  output logic [6:0]  tx_fill_percent,
  output logic [6:0]  rx_fill_percent,
  output logic        link_up
);
`include "assert_macros.svh"

  localparam int TAW = $clog2(TX_RING_DEPTH);
  localparam int RAW = $clog2(RX_RING_DEPTH);
  localparam logic [15:0] TX_MASK = 16'(TX_RING_DEPTH - 1);
  localparam logic [15:0] RX_MASK = 16'(RX_RING_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_BURST = 3'b010, S_DRAIN = 3'b100
  } state_t;

  logic [7:0] tx_mem [TX_RING_DEPTH];
  logic [7:0] rx_mem [RX_RING_DEPTH];

  state_t state;
  logic [15:0] tx_wp, tx_rp, rx_wp, rx_rp;
  logic link_state, msg_open;
  logic [14:0] msg_left;
  logic [31:0] tx_tot, rx_tot, ref_cnt;

  // Burst control: which ring, bytes still to read, bytes still to emit.
  logic burst_rx;
  logic [6:0] rd_left, emit_left;
  logic rd_pend;
  logic [7:0] rd_data;

  logic [15:0] tx_used, rx_used, tx_free;
  assign tx_used = (tx_wp - tx_rp) & TX_MASK;
  assign rx_used = (rx_wp - rx_rp) & RX_MASK;
  assign tx_free = TX_MASK - tx_used;

  // Result register contents other than the stat snapshot.
  logic accept;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept = in_valid && in_ready;
  logic out_free;
  assign out_free = !out_valid || out_ready;

  // Burst lengths: read limit clamp and bytes available in each ring.
  logic [6:0] maxc, tx_n, rx_n;
  always_comb begin
    maxc = (max_count > 7'(strb_pkg::READ_LIMIT)) ? 7'(strb_pkg::READ_LIMIT) : max_count;
    tx_n = (tx_used > 16'(PACKET_MAX)) ? 7'(PACKET_MAX) : tx_used[6:0];
    rx_n = (rx_used > 16'(maxc)) ? maxc : rx_used[6:0];
  end

  logic start_burst, burst_is_rx;
  logic [6:0] burst_n;
  logic [2:0] st_one;
  logic tx_we, rx_we, ref_inc, rx_inc, link_we, clr_tx;
  logic msg_open_next;
  logic [14:0] msg_left_next;
  always_comb begin
    start_burst = 1'b0;
    burst_is_rx = 1'b0;
    burst_n = '0;
    st_one = strb_pkg::ST_OK;
    tx_we = 1'b0;
    rx_we = 1'b0;
    ref_inc = 1'b0;
    rx_inc = 1'b0;
    link_we = 1'b0;
    clr_tx = 1'b0;
    msg_open_next = msg_open;
    msg_left_next = msg_left;
    case (operation)
      strb_pkg::OP_TX_BYTE: begin
        if (first_of_message) begin
          msg_open_next = 1'b0;
          msg_left_next = '0;
          if (!link_state) begin
            st_one = strb_pkg::ST_NOT_CONN;
          end else if (msg_length == 15'd0) begin
            st_one = strb_pkg::ST_OK;
          end else if (16'(msg_length) > tx_free) begin
            ref_inc = 1'b1;
            st_one = strb_pkg::ST_OVERFLOW;
          end else begin
            tx_we = 1'b1;
            msg_left_next = msg_length - 15'd1;
            msg_open_next = (msg_length != 15'd1);
          end
        end else if (!link_state) begin
          st_one = strb_pkg::ST_NOT_CONN;
        end else if (msg_open && msg_left != 15'd0) begin
          if (tx_free == 16'd0) begin
            st_one = strb_pkg::ST_OVERFLOW;
          end else begin
            tx_we = 1'b1;
            msg_left_next = msg_left - 15'd1;
            msg_open_next = (msg_left != 15'd1);
          end
        end
      end
      strb_pkg::OP_FLUSH: begin
        if (!link_state) begin
          st_one = strb_pkg::ST_NOT_CONN;
        end else if (host_busy || tx_used == 16'd0) begin
          st_one = strb_pkg::ST_NOTHING;
        end else if (!transmit_ok) begin
          st_one = strb_pkg::ST_TX_FAIL;
        end else begin
          start_burst = 1'b1;
          burst_n = tx_n;
        end
      end
      strb_pkg::OP_RX_BYTE: begin
        rx_inc = 1'b1;
        if (rx_used < RX_MASK) begin
          rx_we = 1'b1;
        end else begin
          st_one = strb_pkg::ST_DROPPED;
        end
      end
      strb_pkg::OP_RX_READ: begin
        if (rx_n == 7'd0) begin
          st_one = strb_pkg::ST_NOTHING;
        end else begin
          start_burst = 1'b1;
          burst_is_rx = 1'b1;
          burst_n = rx_n;
        end
      end
      strb_pkg::OP_SET_LINK: begin
        link_we = 1'b1;
        if (!connected) begin
          clr_tx = 1'b1;
          msg_open_next = 1'b0;
          msg_left_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory writes and reads.
  logic rd_fire;
  assign rd_fire = (state == S_BURST) && (rd_left != 7'd0) && !rd_pend;

  // The output register is loaded by a single-result item or by a burst byte.
  logic out_load;
  assign out_load = (state == S_IDLE && accept && !start_burst) ||
                    (state == S_BURST && !rd_fire && rd_pend && out_free);

  always_ff @(posedge clk) begin
    if (accept && tx_we) begin
      tx_mem[tx_wp[TAW-1:0]] <= data_byte;
    end
    if (accept && rx_we) begin
      rx_mem[rx_wp[RAW-1:0]] <= data_byte;
    end
    if (rd_fire) begin
      rd_data <= burst_rx ? rx_mem[rx_rp[RAW-1:0]] : tx_mem[tx_rp[TAW-1:0]];
    end
  end

  // Post-item values used for the stat snapshot of a single result.
  logic [15:0] tx_wp_n, tx_rp_n, rx_wp_n;
  logic [31:0] tx_tot_n, rx_tot_n, ref_n;
  logic link_n;
  always_comb begin
    tx_wp_n = clr_tx ? 16'd0 : (tx_we ? tx_wp + 16'd1 : tx_wp);
    tx_rp_n = clr_tx ? 16'd0 : tx_rp;
    rx_wp_n = rx_we ? rx_wp + 16'd1 : rx_wp;
    tx_tot_n = tx_we ? tx_tot + 32'd1 : tx_tot;
    rx_tot_n = rx_inc ? rx_tot + 32'd1 : rx_tot;
    ref_n = ref_inc ? ref_cnt + 32'd1 : ref_cnt;
    link_n = link_we ? connected : link_state;
  end

  // Snapshot sources: accept cycle uses post-item values; bursts use the
  // final pointers, which are known at burst start.
  logic [15:0] snap_txu, snap_rxu;
  logic [31:0] snap_txt, snap_rxt, snap_ref;
  logic snap_link;
  always_comb begin
    snap_txu = (tx_wp_n - tx_rp_n) & TX_MASK;
    snap_rxu = (rx_wp_n - rx_rp) & RX_MASK;
    snap_txt = tx_tot_n;
    snap_rxt = rx_tot_n;
    snap_ref = ref_n;
    snap_link = link_n;
    if (start_burst) begin
      if (burst_is_rx) begin
        snap_rxu = rx_used - 16'(burst_n);
      end else begin
        snap_txu = tx_used - 16'(burst_n);
      end
    end
  end

  // Held stat snapshot for every result, shared by all results of a burst.
  logic [14:0] hold_rxa;
  logic [6:0] hold_txp, hold_rxp;
  logic [31:0] hold_txt, hold_rxt, hold_ref;
  logic hold_link;
  logic [6:0] pct_tx, pct_rx;
  logic [22:0] prod_tx, prod_rx;
  assign prod_tx = 23'(snap_txu) * 23'd100;
  assign prod_rx = 23'(snap_rxu) * 23'd100;
  assign pct_tx = 7'(prod_tx >> TAW);
  assign pct_rx = 7'(prod_rx >> RAW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tx_wp <= '0;
      tx_rp <= '0;
      rx_wp <= '0;
      rx_rp <= '0;
      link_state <= 1'b0;
      msg_open <= 1'b0;
      msg_left <= '0;
      tx_tot <= '0;
      rx_tot <= '0;
      ref_cnt <= '0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
      rd_left <= '0;
      emit_left <= '0;
      burst_rx <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            tx_wp <= tx_wp_n;
            tx_rp <= tx_rp_n;
            rx_wp <= rx_wp_n;
            tx_tot <= tx_tot_n;
            rx_tot <= rx_tot_n;
            ref_cnt <= ref_n;
            link_state <= link_n;
            msg_open <= msg_open_next;
            msg_left <= msg_left_next;
            hold_rxa <= snap_rxu[14:0];
            hold_txp <= pct_tx;
            hold_rxp <= pct_rx;
            hold_txt <= snap_txt;
            hold_rxt <= snap_rxt;
            hold_ref <= snap_ref;
            hold_link <= snap_link;
            if (start_burst) begin
              state <= S_BURST;
              burst_rx <= burst_is_rx;
              rd_left <= burst_n;
              emit_left <= burst_n;
            end else begin
              status <= st_one;
              out_byte <= '0;
              last <= 1'b1;
            end
          end
        end
        S_BURST: begin
          if (rd_fire) begin
            rd_pend <= 1'b1;
            rd_left <= rd_left - 7'd1;
            if (burst_rx) begin
              rx_rp <= rx_rp + 16'd1;
            end else begin
              tx_rp <= tx_rp + 16'd1;
            end
          end else if (rd_pend && out_free) begin
            rd_pend <= 1'b0;
            status <= strb_pkg::ST_OK;
            out_byte <= rd_data;
            last <= (emit_left == 7'd1);
            emit_left <= emit_left - 7'd1;
            if (emit_left == 7'd1) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rx_available = hold_rxa;
  assign tx_fill_percent = hold_txp;
  assign rx_fill_percent = hold_rxp;
  assign tx_byte_count = hold_txt;
  assign rx_byte_count = hold_rxt;
  assign overflow_count = hold_ref;
  assign link_up = hold_link;

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, !in_ready, "input taken mid burst")
  `ASSERT_IMPL(a_ring_slot_free, clk, rst, 1'b1, tx_used != TX_MASK + 16'd1, "tx ring overfull")
  `ASSERT_NEXT(a_burst_last, clk, rst, state == S_BURST && rd_pend && out_free && emit_left == 7'd1,
    out_valid && last, "burst end without last")
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the serial transmit/receive ring buffers.
// Drives operations through the valid/ready input channel, mirrors the two
// rings, the link state and the counters in a predictor, and compares every
// result transfer field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes 6 and 7 are not operations; the block must answer them with OK.
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int TXD = strb_pkg::TX_RING_DEPTH_DEF;
  localparam int RXD = strb_pkg::RX_RING_DEPTH_DEF;
  localparam int PKT = strb_pkg::PACKET_MAX_DEF;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  operation;
  logic [7:0]  data_byte;
  logic [14:0] msg_length;
  logic        first_of_message;
  logic [6:0]  max_count;
  logic        connected;
  logic        host_busy;
  logic        transmit_ok;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic        last;
  logic [14:0] rx_available;
  logic [31:0] tx_byte_count;
  logic [31:0] rx_byte_count;
  logic [31:0] overflow_count;
  logic [6:0]  tx_fill_percent;
  logic [6:0]  rx_fill_percent;
  logic        link_up;

  serial_tx_rx_ring_buffers uut (.*);

  // One expected result transfer, with the block's field widths.
  typedef struct packed {
    logic [2:0]  st;
    logic [7:0]  byte_val;
    logic        is_last;
    logic [14:0] rx_avail;
    logic [31:0] tx_total;
    logic [31:0] rx_total;
    logic [31:0] refused;
    logic [6:0]  tx_fill;
    logic [6:0]  rx_fill;
    logic        link;
  } ring_result_t;

  ring_result_t expected_results[$];
  int errors;

  // Predictor state: a private copy of both rings and all counters.
  logic [7:0]  tx_mem [TXD];
  logic [7:0]  rx_mem [RXD];
  logic [15:0] tx_wp, tx_rp, rx_wp, rx_rp;
  logic        link_q;
  logic        msg_open;
  int unsigned msg_left;
  logic [31:0] tx_count, rx_count, refuse_count;

  // Idle control: when quiet is set, neither side inserts gaps.
  logic quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Random gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // The receiving side stalls in random stretches.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    end
  end

  function automatic int unsigned tx_used();
    return 32'(16'(tx_wp - tx_rp)) & (TXD - 1);
  endfunction

  function automatic int unsigned rx_used();
    return 32'(16'(rx_wp - rx_rp)) & (RXD - 1);
  endfunction

  // Every result carries the state as it stands after its item is done, so
  // results are queued only once the predictor state has been updated.
  function automatic void queue_result(logic [2:0] st, logic [7:0] b, logic lst);
    ring_result_t r;
    r.st       = st;
    r.byte_val = b;
    r.is_last  = lst;
    r.rx_avail = 15'(rx_used());
    r.tx_total = tx_count;
    r.rx_total = rx_count;
    r.refused  = refuse_count;
    r.tx_fill  = 7'((tx_used() * 100) / TXD);
    r.rx_fill  = 7'((rx_used() * 100) / RXD);
    r.link     = link_q;
    expected_results.push_back(r);
  endfunction

  function automatic logic [2:0] tx_enqueue(logic [7:0] b);
    if (TXD - 1 - tx_used() == 0) return strb_pkg::ST_OVERFLOW;
    tx_mem[tx_wp & (TXD - 1)] = b;
    tx_wp++;
    tx_count++;
    if (msg_left > 0) msg_left--;
    if (msg_left == 0) msg_open = 1'b0;
    return strb_pkg::ST_OK;
  endfunction

  // Works out the results of one accepted operation.
  function automatic void predict_op(logic [2:0] op, logic [7:0] b, logic [14:0] len,
                                     logic first, logic [6:0] maxc, logic conn,
                                     logic busy, logic ok);
    logic [2:0]  st;
    logic [7:0]  bytes [PKT];
    int unsigned n, lim;
    st = strb_pkg::ST_OK;
    case (op)
      strb_pkg::OP_TX_BYTE: begin
        if (first) begin
          msg_open = 1'b0;
          msg_left = 0;
          if (!link_q) st = strb_pkg::ST_NOT_CONN;
          else if (len == 0) st = strb_pkg::ST_OK;
          else if (len > TXD - 1 - tx_used()) begin
            refuse_count++;
            st = strb_pkg::ST_OVERFLOW;
          end else begin
            msg_open = 1'b1;
            msg_left = len;
            st = tx_enqueue(b);
          end
        end else if (!link_q) begin
          st = strb_pkg::ST_NOT_CONN;
        end else if (msg_open && msg_left > 0) begin
          st = tx_enqueue(b);
        end
      end
      strb_pkg::OP_FLUSH: begin
        if (!link_q) st = strb_pkg::ST_NOT_CONN;
        else if (busy || tx_used() == 0) st = strb_pkg::ST_NOTHING;
        else if (!ok) st = strb_pkg::ST_TX_FAIL;
        else begin
          n = (tx_used() > PKT) ? PKT : tx_used();
          for (int i = 0; i < n; i++) begin
            bytes[i] = tx_mem[tx_rp & (TXD - 1)];
            tx_rp++;
          end
          for (int i = 0; i < n; i++) queue_result(strb_pkg::ST_OK, bytes[i], i + 1 == n);
          return;
        end
      end
      strb_pkg::OP_RX_BYTE: begin
        rx_count++;
        if (rx_used() < RXD - 1) begin
          rx_mem[rx_wp & (RXD - 1)] = b;
          rx_wp++;
        end else begin
          st = strb_pkg::ST_DROPPED;
        end
      end
      strb_pkg::OP_RX_READ: begin
        lim = (maxc > strb_pkg::READ_LIMIT) ? strb_pkg::READ_LIMIT : maxc;
        n = (rx_used() > lim) ? lim : rx_used();
        if (n == 0) st = strb_pkg::ST_NOTHING;
        else begin
          for (int i = 0; i < n; i++) begin
            bytes[i] = rx_mem[rx_rp & (RXD - 1)];
            rx_rp++;
          end
          for (int i = 0; i < n; i++) queue_result(strb_pkg::ST_OK, bytes[i], i + 1 == n);
          return;
        end
      end
      strb_pkg::OP_SET_LINK: begin
        link_q = conn;
        if (!conn) begin
          tx_wp    = '0;
          tx_rp    = '0;
          msg_open = 1'b0;
          msg_left = 0;
        end
      end
      default: ;
    endcase
    queue_result(st, 8'h00, 1'b1);
  endfunction

  // Sends one item, waits for its transfer, predicts it, then maybe idles.
  // Called at a rising edge; returns at a rising edge.
  task automatic send_op(logic [2:0] op, logic [7:0] b = 8'h00, logic [14:0] len = '0,
                         logic first = 1'b0, logic [6:0] maxc = 7'd0,
                         logic conn = 1'b0, logic busy = 1'b0, logic ok = 1'b1);
    int g;
    in_valid         <= 1'b1;
    operation        <= op;
    data_byte        <= b;
    msg_length       <= len;
    first_of_message <= first;
    max_count        <= maxc;
    connected        <= conn;
    host_busy        <= busy;
    transmit_ok      <= ok;
    do @(posedge clk); while (!in_ready);
    predict_op(op, b, len, first, maxc, conn, busy, ok);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Lets everything outstanding drain before continuing.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // Compares each result transfer against the oldest expectation.
  always @(posedge clk) begin
    ring_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transfer", 32'd1, 32'd0);
      end else begin
        e = expected_results.pop_front();
        if (status != e.st) report_mismatch("status", status, e.st);
        if (out_byte != e.byte_val) report_mismatch("out_byte", out_byte, e.byte_val);
        if (last != e.is_last) report_mismatch("last", last, e.is_last);
        if (rx_available != e.rx_avail) begin
          report_mismatch("rx_available", rx_available, e.rx_avail);
        end
        if (tx_byte_count != e.tx_total) begin
          report_mismatch("tx_byte_count", tx_byte_count, e.tx_total);
        end
        if (rx_byte_count != e.rx_total) begin
          report_mismatch("rx_byte_count", rx_byte_count, e.rx_total);
        end
        if (overflow_count != e.refused) begin
          report_mismatch("overflow_count", overflow_count, e.refused);
        end
        if (tx_fill_percent != e.tx_fill) begin
          report_mismatch("tx_fill_percent", tx_fill_percent, e.tx_fill);
        end
        if (rx_fill_percent != e.rx_fill) begin
          report_mismatch("rx_fill_percent", rx_fill_percent, e.rx_fill);
        end
        if (link_up != e.link) report_mismatch("link_up", link_up, e.link);
      end
    end
  end

  // Directed corner cases: each operation, refused messages, empty paths.
  task automatic test_directed();
    send_op(strb_pkg::OP_STATS);
    send_op(strb_pkg::OP_TX_BYTE, 8'hFF, 15'd3, 1'b1);     // link down refuses
    send_op(strb_pkg::OP_TX_BYTE, 8'h11);                   // stray byte, link down
    send_op(strb_pkg::OP_FLUSH);                            // flush with link down
    send_op(strb_pkg::OP_RX_READ, 8'h00, '0, 1'b0, 7'd10);  // nothing to read
    send_op(strb_pkg::OP_SET_LINK, 8'h00, '0, 1'b0, 7'd0, 1'b1);
    send_op(strb_pkg::OP_FLUSH);                            // empty ring
    send_op(strb_pkg::OP_TX_BYTE, 8'h00, 15'd0, 1'b1);      // zero-length message
    send_op(strb_pkg::OP_TX_BYTE, 8'h22);                   // no open message
    send_op(strb_pkg::OP_TX_BYTE, 8'hAA, 15'h7FFF, 1'b1);   // too long, counted
    send_op(strb_pkg::OP_TX_BYTE, 8'h01, 15'd1024, 1'b1);   // just over free space
    send_op(strb_pkg::OP_TX_BYTE, 8'h5A, 15'd2, 1'b1);
    send_op(strb_pkg::OP_TX_BYTE, 8'hA5);
    send_op(strb_pkg::OP_TX_BYTE, 8'h77);                   // beyond the length
    send_op(strb_pkg::OP_FLUSH, 8'h00, '0, 1'b0, 7'd0, 1'b0, 1'b1, 1'b1);  // host busy
    send_op(strb_pkg::OP_FLUSH, 8'h00, '0, 1'b0, 7'd0, 1'b0, 1'b0, 1'b0);  // transmit fails
    send_op(strb_pkg::OP_FLUSH, 8'h00, '0, 1'b0, 7'd0, 1'b0, 1'b0, 1'b1);
    send_op(strb_pkg::OP_RX_BYTE, 8'h00);
    send_op(strb_pkg::OP_RX_BYTE, 8'hFF);
    send_op(strb_pkg::OP_RX_READ, 8'h00, '0, 1'b0, 7'd0);   // max_count zero
    send_op(strb_pkg::OP_RX_READ, 8'h00, '0, 1'b0, 7'd127); // clamps to the limit
    send_op(OP_RSVD6);
    send_op(OP_RSVD7, 8'hFF, 15'h7FFF, 1'b1, 7'h7F, 1'b1, 1'b1, 1'b1);
    drain();
  endtask

  // Sends one message, refuses a second one just over the free space, then
  // flushes and disconnects.
  task automatic test_tx_fill();
    int len;
    quiet = 1'b1;
    send_op(strb_pkg::OP_SET_LINK, 8'h00, '0, 1'b0, 7'd0, 1'b1);
    len = $urandom_range(20, 40);
    send_op(strb_pkg::OP_TX_BYTE, 8'($urandom), 15'(len), 1'b1);
    for (int i = 1; i < len; i++) send_op(strb_pkg::OP_TX_BYTE, 8'($urandom));
    quiet = 1'b0;
    // Free space plus one.
    send_op(strb_pkg::OP_TX_BYTE, 8'h00, 15'(TXD - int'(tx_used())), 1'b1);
    send_op(strb_pkg::OP_FLUSH, 8'h00, '0, 1'b0, 7'd0, 1'b0, 1'b0, 1'b1);
    send_op(strb_pkg::OP_STATS);
    send_op(strb_pkg::OP_SET_LINK, 8'h00, '0, 1'b0, 7'd0, 1'b0);  // clears tx ring
    send_op(strb_pkg::OP_STATS);
    drain();
  endtask

  // Random traffic: mostly well-formed messages with flushes and reads,
  // the rest noise, broken messages and link changes.
  task automatic test_random(int items);
    int sent, len, r;
    sent = 0;
    send_op(strb_pkg::OP_SET_LINK, 8'h00, '0, 1'b0, 7'd0, 1'b1);
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 90);
        send_op(strb_pkg::OP_TX_BYTE, 8'($urandom), 15'(len), 1'b1);
        sent++;
        if (len < 200) begin
          // Sometimes cut the message short or overrun it.
          len = len + $urandom_range(0, 2) - ($urandom_range(0, 4) == 0 ? len / 2 : 0);
          for (int i = 1; i < len; i++) begin
            send_op(strb_pkg::OP_TX_BYTE, 8'($urandom), 15'($urandom), 1'b0);
            sent++;
          end
        end
      end else if (r < 55) begin
        send_op(strb_pkg::OP_FLUSH, 8'($urandom), 15'($urandom), 1'($urandom),
                7'($urandom), 1'($urandom), ($urandom_range(0, 5) == 0),
                ($urandom_range(0, 5) != 0));
        sent++;
      end else if (r < 72) begin
        send_op(strb_pkg::OP_RX_BYTE, 8'($urandom), 15'($urandom), 1'($urandom));
        sent++;
      end else if (r < 85) begin
        send_op(strb_pkg::OP_RX_READ, 8'($urandom), 15'($urandom), 1'b0,
                ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 64)));
        sent++;
      end else if (r < 91) begin
        send_op(strb_pkg::OP_SET_LINK, 8'($urandom), 15'($urandom), 1'($urandom),
                7'($urandom), ($urandom_range(0, 3) != 0));
        sent++;
      end else begin
        send_op(3'($urandom_range(strb_pkg::OP_STATS, OP_RSVD7)), 8'($urandom),
                15'($urandom), 1'($urandom), 7'($urandom));
        sent++;
      end
      // Hold off the sender until every expected result has come, after each item just past halfway.
      if (sent > items / 2 && sent < items / 2 + 8) drain();
    end
    drain();
  endtask

  initial begin
    errors           = 0;
    quiet            = 1'b0;
    tx_wp = '0; tx_rp = '0; rx_wp = '0; rx_rp = '0;
    link_q = 1'b0; msg_open = 1'b0; msg_left = 0;
    tx_count = '0; rx_count = '0; refuse_count = '0;
    rst              = 1'b1;
    in_valid         = 1'b0;
    operation        = strb_pkg::OP_STATS;
    data_byte        = '0;
    msg_length       = '0;
    first_of_message = 1'b0;
    max_count        = '0;
    connected        = 1'b0;
    host_busy        = 1'b0;
    transmit_ok      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_tx_fill();
    test_random(340);

    repeat (80) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
